@@ src/ptt_pkg.sv @@
// Shared types and constants for the periodic timer table.
// Used by ptt_table, ptt_ctrl, the top level and the checker; no dependencies.
package ptt_pkg;

  localparam int SLOT_W     = 4;
  localparam int PERIOD_W   = 15;
  localparam int WINDOW_W   = 16;
  localparam int STATUS_W   = 3;
  localparam int OP_W       = 2;

  localparam int NUM_TIMERS_DEF    = 10;
  localparam int PRESCALE_LOG2_DEF = 3;

  localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DELETED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EXPIRED  = 3'd4;

  typedef struct packed {
    logic                en;
    logic [SLOT_W-1:0]   idx;
    logic [PERIOD_W-1:0] period;
    logic [PERIOD_W-1:0] count;
    logic [WINDOW_W-1:0] window;
  } tbl_wr_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [PERIOD_W-1:0] count;
    logic [WINDOW_W-1:0] window;
  } tbl_rd_t;

endpackage

@@ src/ptt_table.sv @@
// Timer slot storage: reload period, countdown and owner window per slot.
// One read address, one write port. Depends on ptt_pkg.
module ptt_table import ptt_pkg::*; #(
  parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [SLOT_W-1:0] rd_idx,
  output tbl_rd_t           rd,
  input  tbl_wr_t           wr
);

  localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  logic [PERIOD_W-1:0] period_r [NUM_TIMERS];
  logic [PERIOD_W-1:0] count_r  [NUM_TIMERS];
  logic [WINDOW_W-1:0] window_r [NUM_TIMERS];

  // period of zero marks a free slot, so only it needs reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        period_r[i] <= '0;
      end
    end else if (wr.en) begin
      period_r[wr.idx[IW-1:0]] <= wr.period;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      count_r[wr.idx[IW-1:0]]  <= wr.count;
      window_r[wr.idx[IW-1:0]] <= wr.window;
    end
  end

  assign rd.period = period_r[rd_idx[IW-1:0]];
  assign rd.count  = count_r[rd_idx[IW-1:0]];
  assign rd.window = window_r[rd_idx[IW-1:0]];

endmodule

@@ src/ptt_ctrl.sv @@
// Sequencer for the timer table: walks slots one per cycle with a shared
// decrement/zero-detect unit, runs the prescaler, drives the result beat.
// Depends on ptt_pkg.
module ptt_ctrl import ptt_pkg::*; #(
  parameter int NUM_TIMERS    = NUM_TIMERS_DEF,
  parameter int PRESCALE_LOG2 = PRESCALE_LOG2_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [OP_W-1:0]     in_operation,
  input  logic [PERIOD_W-1:0] in_period,
  input  logic [WINDOW_W-1:0] in_window_id,
  input  logic [SLOT_W-1:0]   in_slot_index,
  input  logic                tick_hold,
  output logic [SLOT_W-1:0]   rd_idx,
  input  tbl_rd_t             rd,
  output tbl_wr_t             wr,
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic [SLOT_W-1:0]   out_slot,
  output logic [WINDOW_W-1:0] out_window,
  output logic                out_last
);

  localparam int PW = (PRESCALE_LOG2 > 0) ? PRESCALE_LOG2 : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_TIMERS - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_TICK  = 3'd1;
  localparam logic [2:0] S_FLUSH = 3'd2;
  localparam logic [2:0] S_INS   = 3'd3;
  localparam logic [2:0] S_DEL   = 3'd4;

  logic [2:0]          state_r, state_nxt;
  logic [SLOT_W-1:0]   ptr_r, ptr_nxt;
  logic [PW-1:0]       pre_r, pre_nxt;
  logic [PERIOD_W-1:0] ins_period_r, ins_period_nxt;
  logic [WINDOW_W-1:0] ins_window_r, ins_window_nxt;
  logic                pend_r, pend_nxt;
  logic [SLOT_W-1:0]   pend_slot_r, pend_slot_nxt;
  logic [WINDOW_W-1:0] pend_win_r, pend_win_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]   out_slot_r, out_slot_nxt;
  logic [WINDOW_W-1:0] out_window_r, out_window_nxt;
  logic                out_last_r, out_last_nxt;

  // shared unit: countdown decrement and zero detect
  logic [PERIOD_W-1:0] dec;
  logic                dec_zero;
  logic                active;

  assign dec      = rd.count - PERIOD_W'(1);
  assign dec_zero = (dec == '0);
  assign active   = (rd.period != '0);
  assign rd_idx   = ptr_r;
  assign busy     = (state_r != S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    ptr_nxt        = ptr_r;
    pre_nxt        = pre_r;
    ins_period_nxt = ins_period_r;
    ins_window_nxt = ins_window_r;
    pend_nxt       = pend_r;
    pend_slot_nxt  = pend_slot_r;
    pend_win_nxt   = pend_win_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = ST_INSERTED;
    out_slot_nxt   = '0;
    out_window_nxt = '0;
    out_last_nxt   = 1'b0;
    wr             = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_operation)
            OP_TICK: begin
              pre_nxt = (PRESCALE_LOG2 == 0) ? '0 : pre_r + PW'(1);
              if (pre_r == '0 && !tick_hold) begin
                ptr_nxt   = '0;
                pend_nxt  = 1'b0;
                state_nxt = S_TICK;
              end
            end
            OP_INSERT: begin
              ins_period_nxt = in_period;
              ins_window_nxt = in_window_id;
              ptr_nxt        = '0;
              state_nxt      = S_INS;
            end
            OP_DELETE: begin
              ptr_nxt   = in_slot_index;
              state_nxt = S_DEL;
            end
            default: ;
          endcase
        end
      end

      S_TICK: begin
        if (active) begin
          wr.en     = 1'b1;
          wr.idx    = ptr_r;
          wr.period = rd.period;
          wr.window = rd.window;
          wr.count  = dec_zero ? rd.period : dec;
          if (dec_zero) begin
            // hold each expiry until the next one or the flush so the final one can carry last
            if (pend_r) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_EXPIRED;
              out_slot_nxt   = pend_slot_r;
              out_window_nxt = pend_win_r;
            end
            pend_nxt      = 1'b1;
            pend_slot_nxt = ptr_r;
            pend_win_nxt  = rd.window;
          end
        end
        if (ptr_r == LAST_SLOT) begin
          state_nxt = S_FLUSH;
        end else begin
          ptr_nxt = ptr_r + SLOT_W'(1);
        end
      end

      S_FLUSH: begin
        if (pend_r) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_EXPIRED;
          out_slot_nxt   = pend_slot_r;
          out_window_nxt = pend_win_r;
          out_last_nxt   = 1'b1;
        end
        pend_nxt  = 1'b0;
        state_nxt = S_IDLE;
      end

      S_INS: begin
        if (!active) begin
          wr.en          = 1'b1;
          wr.idx         = ptr_r;
          wr.period      = ins_period_r;
          wr.count       = ins_period_r;
          wr.window      = ins_window_r;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_INSERTED;
          out_slot_nxt   = ptr_r;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end else if (ptr_r == LAST_SLOT) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_FULL;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          ptr_nxt = ptr_r + SLOT_W'(1);
        end
      end

      S_DEL: begin
        out_valid_nxt = 1'b1;
        out_last_nxt  = 1'b1;
        if (({1'b0, ptr_r} >= (SLOT_W+1)'(NUM_TIMERS)) || !active) begin
          out_status_nxt = ST_REJECTED;
        end else begin
          wr.en          = 1'b1;
          wr.idx         = ptr_r;
          out_status_nxt = ST_DELETED;
          out_slot_nxt   = ptr_r;
        end
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ptr_r       <= '0;
      pre_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      pre_r       <= pre_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ins_period_r <= ins_period_nxt;
    ins_window_r <= ins_window_nxt;
    pend_slot_r  <= pend_slot_nxt;
    pend_win_r   <= pend_win_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_window_r <= out_window_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_slot   = out_slot_r;
  assign out_window = out_window_r;
  assign out_last   = out_last_r;

endmodule

@@ src/periodic_timer_table_unit.sv @@
// Top level of the periodic timer table: hold register, sequencer, slot store.
// Instantiates ptt_ctrl and ptt_table; depends on ptt_pkg.
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------------
//  input    | start, busy          | in_operation, in_period, in_window_id,
//           |                      | in_slot_index
//  result   | out_valid (strobe)   | out_status, out_slot, out_window, out_last
//  config   | cfg_valid, cfg_ready | cfg_tick_hold
//
// A beat is taken at a rising edge with start high and busy low. Unscanned
// ticks and unused codes finish without leaving idle; a delete visits only
// its own slot; an insert walks slots up to the first free one (all of them
// when full); a scanned tick walks every slot and then flushes. The walk is
// paced by the single table read port and the one decrement unit, which
// visit one slot per cycle. Reset (rst_n low, synchronous) frees all slots,
// clears the prescaler and the hold bit. Results are one-cycle strobes; the
// receiver cannot stall, so busy depends only on the sequencer.
module periodic_timer_table_unit import ptt_pkg::*; #(
  parameter int NUM_TIMERS    = NUM_TIMERS_DEF,
  parameter int PRESCALE_LOG2 = PRESCALE_LOG2_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [OP_W-1:0]     in_operation,
  input  logic [PERIOD_W-1:0] in_period,
  input  logic [WINDOW_W-1:0] in_window_id,
  input  logic [SLOT_W-1:0]   in_slot_index,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_tick_hold,
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic [SLOT_W-1:0]   out_slot,
  output logic [WINDOW_W-1:0] out_window,
  output logic                out_last
);

  logic              hold_r, hold_nxt;
  logic [SLOT_W-1:0] rd_idx;
  tbl_rd_t           rd;
  tbl_wr_t           wr;

  // config is to land only while idle (the block does not enforce this); the write is always taken
  assign cfg_ready = 1'b1;
  assign hold_nxt  = (cfg_valid && cfg_ready) ? cfg_tick_hold : hold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
    end else begin
      hold_r <= hold_nxt;
    end
  end

  // sequencer: prescaler, slot walk, shared decrement, result register
  ptt_ctrl #(
    .NUM_TIMERS    (NUM_TIMERS),
    .PRESCALE_LOG2 (PRESCALE_LOG2)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_operation  (in_operation),
    .in_period     (in_period),
    .in_window_id  (in_window_id),
    .in_slot_index (in_slot_index),
    .tick_hold     (hold_r),
    .rd_idx        (rd_idx),
    .rd            (rd),
    .wr            (wr),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_slot      (out_slot),
    .out_window    (out_window),
    .out_last      (out_last)
  );

  // slot store: one read address (the walk pointer), one write
  ptt_table #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_idx (rd_idx),
    .rd     (rd),
    .wr     (wr)
  );

endmodule

@@ src/ptt_checker.sv @@
// Port-level checks for periodic_timer_table_unit, attached by bind.
// Depends on ptt_pkg.
module ptt_checker import ptt_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic [OP_W-1:0]     in_operation,
  input logic                out_valid,
  input logic [STATUS_W-1:0] out_status,
  input logic [WINDOW_W-1:0] out_window,
  input logic                out_last
);

  // an accepted insert or delete always goes busy
  a_cmd_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_operation == OP_INSERT || in_operation == OP_DELETE))
    |=> busy)
    else $error("insert/delete accepted without going busy");

  // only expiries come in bursts; others are single beats
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_EXPIRED) |-> out_last)
    else $error("non-expiry beat without last");

  a_window_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_EXPIRED) |-> (out_window == '0))
    else $error("window set on non-expiry beat");

  // the beat after a final one can never be a result
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !out_valid)
    else $error("result beat right after a last beat");

endmodule

bind periodic_timer_table_unit ptt_checker u_ptt_checker (.*);
